@@ src/i2cseq_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and constants for the I2C register-transfer sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int ReadLengthDefault = 14;

  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [1:0] {
    CMD_START_READ  = 2'd0,
    CMD_START_WRITE = 2'd1,
    CMD_BUS_DONE    = 2'd2,
    CMD_UNUSED      = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_TX      = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_RXEN    = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_NACK    = 3'd6,
    ACT_STOP    = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    PH_DEV     = 4'd1,
    PH_REG     = 4'd2,
    PH_WDATA   = 4'd3,
    PH_RESTART = 4'd4,
    PH_ADDR_RD = 4'd5,
    PH_RXEN    = 4'd6,
    PH_RXBYTE  = 4'd7,
    PH_STOP    = 4'd8,
    PH_FINISH  = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [5:0] burst_count;
    logic       write_mode;
    logic       free_flag;
    logic [7:0] latched_device;
    logic [7:0] latched_register;
    logic [7:0] latched_data;
  } seq_state_t;

  typedef struct packed {
    action_t    bus_action;
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       bus_free;
  } seq_result_t;

endpackage

@@ src/i2cseq_step.sv @@
// ----------------------------------------------------------------------------
// i2cseq_step
// Next-state and result logic for one command or bus-completion event.
// ----------------------------------------------------------------------------
module i2cseq_step #(
  parameter int READ_LENGTH = i2cseq_pkg::ReadLengthDefault
) (
  input  i2cseq_pkg::seq_state_t  cur,
  input  logic [1:0]              command,
  input  logic [7:0]              device_address,
  input  logic [7:0]              register_address,
  input  logic [7:0]              write_data,
  input  logic [7:0]              received_byte,
  output i2cseq_pkg::seq_state_t  nxt,
  output i2cseq_pkg::seq_result_t res
);

  localparam logic [6:0] ReadLen = 7'(READ_LENGTH);

  logic [6:0] count_inc;

  assign count_inc = {1'b0, cur.burst_count} + 7'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    res.bus_action = i2cseq_pkg::ACT_NONE;

    unique case (command)
      i2cseq_pkg::CMD_START_READ, i2cseq_pkg::CMD_START_WRITE: begin
        nxt.latched_device   = device_address;
        nxt.latched_register = register_address;
        if (command == i2cseq_pkg::CMD_START_WRITE) begin
          nxt.latched_data = write_data;
        end
        nxt.write_mode  = command[0];
        nxt.free_flag   = 1'b0;
        nxt.phase       = i2cseq_pkg::PH_DEV;
        nxt.burst_count = '0;
        res.bus_action  = i2cseq_pkg::ACT_START;
      end
      i2cseq_pkg::CMD_BUS_DONE: begin
        unique case (cur.phase)
          i2cseq_pkg::PH_DEV: begin
            res.bus_action = i2cseq_pkg::ACT_TX;
            res.tx_byte    = cur.latched_device;
            nxt.phase      = i2cseq_pkg::PH_REG;
          end
          i2cseq_pkg::PH_REG: begin
            res.bus_action = i2cseq_pkg::ACT_TX;
            res.tx_byte    = cur.latched_register;
            nxt.phase      = cur.write_mode ? i2cseq_pkg::PH_WDATA : i2cseq_pkg::PH_RESTART;
          end
          i2cseq_pkg::PH_WDATA: begin
            res.bus_action = i2cseq_pkg::ACT_TX;
            res.tx_byte    = cur.latched_data;
            nxt.phase      = i2cseq_pkg::PH_STOP;
          end
          i2cseq_pkg::PH_RESTART: begin
            res.bus_action = i2cseq_pkg::ACT_RESTART;
            nxt.phase      = i2cseq_pkg::PH_ADDR_RD;
          end
          i2cseq_pkg::PH_ADDR_RD: begin
            res.bus_action = i2cseq_pkg::ACT_TX;
            res.tx_byte    = cur.latched_device | i2cseq_pkg::ReadBit;
            nxt.phase      = i2cseq_pkg::PH_RXEN;
          end
          i2cseq_pkg::PH_RXEN: begin
            res.bus_action = i2cseq_pkg::ACT_RXEN;
            nxt.phase      = i2cseq_pkg::PH_RXBYTE;
          end
          i2cseq_pkg::PH_RXBYTE: begin
            res.store_valid = 1'b1;
            res.store_index = cur.burst_count;
            res.store_byte  = received_byte;
            if (count_inc >= ReadLen) begin
              res.bus_action  = i2cseq_pkg::ACT_NACK;
              nxt.burst_count = '0;
              nxt.phase       = i2cseq_pkg::PH_STOP;
            end else begin
              res.bus_action  = i2cseq_pkg::ACT_ACK;
              nxt.burst_count = count_inc[5:0];
              nxt.phase       = i2cseq_pkg::PH_RXEN;
            end
          end
          i2cseq_pkg::PH_STOP: begin
            res.bus_action = i2cseq_pkg::ACT_STOP;
            nxt.phase      = i2cseq_pkg::PH_FINISH;
          end
          i2cseq_pkg::PH_FINISH: begin
            nxt.free_flag = 1'b1;
            nxt.phase     = i2cseq_pkg::PH_DEV;
          end
          default: begin
            nxt.phase = i2cseq_pkg::PH_DEV;
          end
        endcase
      end
      default: begin
        // unused code: no state change, empty result but for bus_free
      end
    endcase

    res.bus_free = nxt.free_flag;
  end

endmodule

@@ src/i2c_interrupt_transaction_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_interrupt_transaction_sequencer
// Event-driven I2C master sequencer for single register writes and burst reads.
// ----------------------------------------------------------------------------
// Each accepted transfer on the request channel yields exactly one result
// transfer, issued from the result register; a new request can be taken
// every cycle unless the result channel stalls: the sequencer state and
// the result register both update in the cycle of acceptance. A start-read
// or start-write command latches the addresses and data and answers START;
// each bus-done event then walks the sequence (device address, register,
// data or restart plus read address, receive enable and ACK/NACK per byte,
// STOP, then a final event that raises bus_free). The single result
// register is refilled while it is being drained, so the request side
// stalls only when a result sits unclaimed under a stalled result channel.
module i2c_interrupt_transaction_sequencer #(
  parameter int READ_LENGTH = i2cseq_pkg::ReadLengthDefault
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] command,
  input  logic [7:0] device_address,
  input  logic [7:0] register_address,
  input  logic [7:0] write_data,
  input  logic [7:0] received_byte,
  // result channel
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [2:0] bus_action,
  output logic [7:0] tx_byte,
  output logic       store_valid,
  output logic [5:0] store_index,
  output logic [7:0] store_byte,
  output logic       bus_free
);

  i2cseq_pkg::seq_state_t  state;
  i2cseq_pkg::seq_state_t  state_next;
  i2cseq_pkg::seq_result_t step_res;
  i2cseq_pkg::seq_result_t result;
  logic                    accept;

  // Sequence logic: pure combinational, one pass per transfer.
  i2cseq_step #(
    .READ_LENGTH (READ_LENGTH)
  ) u_step (
    .cur              (state),
    .command          (command),
    .device_address   (device_address),
    .register_address (register_address),
    .write_data       (write_data),
    .received_byte    (received_byte),
    .nxt              (state_next),
    .res              (step_res)
  );

  // Output register frees up in the same cycle it is drained.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= i2cseq_pkg::PH_DEV;
      state.burst_count      <= '0;
      state.write_mode       <= 1'b0;
      state.free_flag        <= 1'b0;
      state.latched_device   <= '0;
      state.latched_register <= '0;
      state.latched_data     <= '0;
      rsp_valid              <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload: loaded on acceptance, held otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_res;
    end
  end

  assign bus_action  = result.bus_action;
  assign tx_byte     = result.tx_byte;
  assign store_valid = result.store_valid;
  assign store_index = result.store_index;
  assign store_byte  = result.store_byte;
  assign bus_free    = result.bus_free;

endmodule
